[hw/rtl/wsrs_pkg.sv]
// Shared widths, codes and register defaults of the wash start retry sequencer.
`timescale 1ns / 1ps
`default_nettype none
package wsrs_pkg;

	// field widths
	localparam int STATE_W  = 4;
	localparam int COUNT_W  = 8;
	localparam int EVENT_W  = 3;
	localparam int REASON_W = 3;
	localparam int TIME_W   = 32;
	localparam int SEC_W    = 16;

	// delays are held in milliseconds: 65535 s * 1000 fits in 26 bits
	localparam int MS_PER_SECOND = 1000;
	localparam int DELAY_MS_W    = 26;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTER_WASH_DELAY = 2'd2;

	localparam logic [COUNT_W-1:0]    MAX_ATTEMPTS_RST     = 8'd3;
	localparam logic [DELAY_MS_W-1:0] RETRY_DELAY_MS_RST   = 26'd5000;
	localparam logic [DELAY_MS_W-1:0] INTER_WASH_MS_RST    = 26'd10000;

	// event codes
	localparam logic [EVENT_W-1:0] EVT_NONE          = 3'd0;
	localparam logic [EVENT_W-1:0] EVT_ESTOP_ACTIVE  = 3'd1;
	localparam logic [EVENT_W-1:0] EVT_ESTOP_CLEARED = 3'd2;
	localparam logic [EVENT_W-1:0] EVT_START_ATTEMPT = 3'd3;
	localparam logic [EVENT_W-1:0] EVT_STARTED       = 3'd4;
	localparam logic [EVENT_W-1:0] EVT_COMPLETED     = 3'd5;
	localparam logic [EVENT_W-1:0] EVT_FAULT         = 3'd6;

	// fault reasons
	localparam logic [REASON_W-1:0] FR_NONE          = 3'd0;
	localparam logic [REASON_W-1:0] FR_IDLE_DEQUEUE  = 3'd1;
	localparam logic [REASON_W-1:0] FR_RELAY_FAILURE = 3'd2;
	localparam logic [REASON_W-1:0] FR_NO_BUSY       = 3'd3;
	localparam logic [REASON_W-1:0] FR_QUEUED_LAUNCH = 3'd4;
	localparam logic [REASON_W-1:0] FR_BAD_STATE     = 3'd5;

endpackage
`default_nettype wire

[hw/rtl/wsrs_if.sv]
// Update and result channel interfaces of the wash start retry sequencer.
`timescale 1ns / 1ps
`default_nettype none
interface wsrs_upd_if;
	import wsrs_pkg::*;

	logic              valid;
	logic              ready;
	logic              estop_active;
	logic              busy_confirmed;
	logic              busy_raw;
	logic              queue_empty;
	logic              dequeue_ok;
	logic              relay_start_ok;
	logic              relay_running;
	logic              clear_fault;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, estop_active, busy_confirmed, busy_raw, queue_empty,
		dequeue_ok, relay_start_ok, relay_running, clear_fault, now_ms, input ready);
	modport sink (input valid, estop_active, busy_confirmed, busy_raw, queue_empty,
		dequeue_ok, relay_start_ok, relay_running, clear_fault, now_ms, output ready);
endinterface

interface wsrs_res_if;
	import wsrs_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATE_W-1:0]  machine_state;
	logic [COUNT_W-1:0]  attempt_count;
	logic [COUNT_W-1:0]  retry_count;
	logic                dequeue_request;
	logic                relay_start_request;
	logic                queue_clear_request;
	logic [EVENT_W-1:0]  event_code;
	logic                retry_started;
	logic [COUNT_W-1:0]  event_value;
	logic [REASON_W-1:0] fault_reason;
	logic                busy_flag;
	logic                faulted_flag;

	modport source (output valid, machine_state, attempt_count, retry_count,
		dequeue_request, relay_start_request, queue_clear_request, event_code,
		retry_started, event_value, fault_reason, busy_flag, faulted_flag, input ready);
	modport sink (input valid, machine_state, attempt_count, retry_count,
		dequeue_request, relay_start_request, queue_clear_request, event_code,
		retry_started, event_value, fault_reason, busy_flag, faulted_flag, output ready);
endinterface
`default_nettype wire

[hw/rtl/wash_start_retry_sequencer.sv]
// Top level of the wash start retry sequencer: input register, state update, result register.
`timescale 1ns / 1ps
`default_nettype none
// One update beat in, one result beat out. The block takes a beat every cycle while the
// result side is not stalled; each beat passes the input register, then the result
// register. The rate is set by a single next-state pass per update, whose
// longest path is the 32-bit wrapped elapsed-time subtract and compare
// against the delay in milliseconds (converted from seconds when the register is
// written). An emergency stop overrides every state and requests a queue clear. A
// relay start that does not bring busy is retried after the retry delay until
// max_attempts starts are made, then the block faults. Configuration writes take
// effect at once and are expected only while no beat is in flight.
module wash_start_retry_sequencer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [wsrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [wsrs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	wsrs_upd_if.sink                           update,
	wsrs_res_if.source                         result
);
	import wsrs_pkg::*;

	typedef enum logic [STATE_W-1:0] {
		ST_IDLE        = 4'd0,
		ST_STARTING    = 4'd1,
		ST_WAIT_BUSY   = 4'd2,
		ST_RUNNING     = 4'd3,
		ST_RELEASE     = 4'd4,
		ST_QUEUE_DELAY = 4'd5,
		ST_RETRY_DELAY = 4'd6,
		ST_FAULT       = 4'd7,
		ST_ESTOP       = 4'd8
	} state_t;

	typedef struct packed {
		logic              estop_active;
		logic              busy_confirmed;
		logic              busy_raw;
		logic              queue_empty;
		logic              dequeue_ok;
		logic              relay_start_ok;
		logic              relay_running;
		logic              clear_fault;
		logic [TIME_W-1:0] now_ms;
	} upd_t;

	typedef struct packed {
		logic [STATE_W-1:0]  machine_state;
		logic [COUNT_W-1:0]  attempt_count;
		logic [COUNT_W-1:0]  retry_count;
		logic                dequeue_request;
		logic                relay_start_request;
		logic                queue_clear_request;
		logic [EVENT_W-1:0]  event_code;
		logic                retry_started;
		logic [COUNT_W-1:0]  event_value;
		logic [REASON_W-1:0] fault_reason;
		logic                busy_flag;
		logic                faulted_flag;
	} res_t;

	// configuration
	logic [COUNT_W-1:0]    max_attempts_q;
	logic [DELAY_MS_W-1:0] retry_ms_q;
	logic [DELAY_MS_W-1:0] inter_wash_ms_q;
	logic [DELAY_MS_W-1:0] cfg_ms;

	// sequencer state
	state_t             state_q;
	logic [COUNT_W-1:0] attempts_q;
	logic [COUNT_W-1:0] retries_q;
	logic [TIME_W-1:0]  entry_q;

	// pipeline
	logic valid_s1;
	upd_t upd_s1;
	logic res_valid_q;
	res_t res_q;
	logic advance;

	// next-state values
	state_t             st_n;
	logic [COUNT_W-1:0] att_n;
	logic [COUNT_W-1:0] ret_n;
	logic [TIME_W-1:0]  entry_n;
	res_t               res_n;
	logic [TIME_W-1:0]  elapsed;
	logic               retry_done;
	logic               inter_done;

	// seconds to milliseconds at write time
	assign cfg_ms = DELAY_MS_W'({{(DELAY_MS_W-CFG_DATA_W){1'b0}}, cfg_wdata} *
		DELAY_MS_W'(MS_PER_SECOND));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_attempts_q  <= MAX_ATTEMPTS_RST;
			retry_ms_q      <= RETRY_DELAY_MS_RST;
			inter_wash_ms_q <= INTER_WASH_MS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_ATTEMPTS:     max_attempts_q  <= cfg_wdata[COUNT_W-1:0];
				CFG_RETRY_DELAY:      retry_ms_q      <= cfg_ms;
				CFG_INTER_WASH_DELAY: inter_wash_ms_q <= cfg_ms;
				default: ;
			endcase
		end
	end

	// handshake: the input stage moves when the result register is free or drained
	assign advance      = valid_s1 && (!res_valid_q || result.ready);
	assign update.ready = !valid_s1 || advance;

	// wrapped elapsed time since the last state change
	assign elapsed    = upd_s1.now_ms - entry_q;
	assign retry_done = elapsed >= {{(TIME_W-DELAY_MS_W){1'b0}}, retry_ms_q};
	assign inter_done = elapsed >= {{(TIME_W-DELAY_MS_W){1'b0}}, inter_wash_ms_q};

	// one update of the sequencer
	always_comb begin
		state_t             eff;
		logic [COUNT_W-1:0] att_inc;
		logic               to_fault;
		logic [REASON_W-1:0] reason;

		st_n     = state_q;
		att_n    = attempts_q;
		ret_n    = retries_q;
		entry_n  = entry_q;
		res_n    = '0;
		eff      = state_q;
		att_inc  = (attempts_q != '1) ? attempts_q + COUNT_W'(1) : attempts_q;
		to_fault = 1'b0;
		reason   = FR_NONE;

		if (upd_s1.estop_active) begin
			if (state_q != ST_ESTOP) begin
				res_n.queue_clear_request = 1'b1;
				res_n.event_code          = EVT_ESTOP_ACTIVE;
				att_n   = '0;
				ret_n   = '0;
				st_n    = ST_ESTOP;
				entry_n = upd_s1.now_ms;
			end else if (!upd_s1.queue_empty) begin
				res_n.queue_clear_request = 1'b1;
			end
		end else begin
			// leaving estop runs the idle handling in the same update
			if (state_q == ST_ESTOP) begin
				res_n.event_code = EVT_ESTOP_CLEARED;
				att_n   = '0;
				ret_n   = '0;
				st_n    = ST_IDLE;
				entry_n = upd_s1.now_ms;
				eff     = ST_IDLE;
			end
			case (eff)
				ST_IDLE: begin
					att_n = '0;
					ret_n = '0;
					if (!upd_s1.queue_empty) begin
						res_n.dequeue_request = 1'b1;
						if (upd_s1.dequeue_ok) begin
							st_n    = ST_STARTING;
							entry_n = upd_s1.now_ms;
						end else begin
							to_fault = 1'b1;
							reason   = FR_IDLE_DEQUEUE;
						end
					end
				end
				ST_STARTING: begin
					res_n.relay_start_request = 1'b1;
					if (upd_s1.relay_start_ok) begin
						att_n = att_inc;
						if (att_inc > COUNT_W'(1)) ret_n = att_inc - COUNT_W'(1);
						res_n.retry_started = (ret_n != '0);
						res_n.event_code    = EVT_START_ATTEMPT;
						res_n.event_value   = att_inc;
						st_n    = ST_WAIT_BUSY;
						entry_n = upd_s1.now_ms;
					end else begin
						to_fault = 1'b1;
						reason   = FR_RELAY_FAILURE;
					end
				end
				ST_WAIT_BUSY: begin
					if (upd_s1.busy_confirmed) begin
						res_n.event_code  = EVT_STARTED;
						res_n.event_value = attempts_q;
						st_n    = ST_RUNNING;
						entry_n = upd_s1.now_ms;
					end else if (!upd_s1.relay_running) begin
						if (attempts_q >= max_attempts_q) begin
							to_fault = 1'b1;
							reason   = FR_NO_BUSY;
						end else begin
							st_n    = ST_RETRY_DELAY;
							entry_n = upd_s1.now_ms;
						end
					end
				end
				ST_RETRY_DELAY: begin
					if (retry_done) begin
						st_n    = ST_STARTING;
						entry_n = upd_s1.now_ms;
					end
				end
				ST_RUNNING: begin
					if (!upd_s1.busy_raw) begin
						st_n    = ST_RELEASE;
						entry_n = upd_s1.now_ms;
					end
				end
				ST_RELEASE: begin
					if (upd_s1.busy_raw) begin
						st_n    = ST_RUNNING;
						entry_n = upd_s1.now_ms;
					end else if (!upd_s1.busy_confirmed) begin
						res_n.event_code  = EVT_COMPLETED;
						res_n.event_value = attempts_q;
						att_n   = '0;
						ret_n   = '0;
						st_n    = upd_s1.queue_empty ? ST_IDLE : ST_QUEUE_DELAY;
						entry_n = upd_s1.now_ms;
					end
				end
				ST_QUEUE_DELAY: begin
					if (upd_s1.queue_empty) begin
						st_n    = ST_IDLE;
						entry_n = upd_s1.now_ms;
					end else if (inter_done) begin
						res_n.dequeue_request = 1'b1;
						if (!upd_s1.dequeue_ok) begin
							to_fault = 1'b1;
							reason   = FR_QUEUED_LAUNCH;
						end else begin
							att_n   = '0;
							ret_n   = '0;
							st_n    = ST_STARTING;
							entry_n = upd_s1.now_ms;
						end
					end
				end
				ST_FAULT: begin
					if (upd_s1.clear_fault) res_n.queue_clear_request = 1'b1;
					att_n   = '0;
					ret_n   = '0;
					st_n    = ST_IDLE;
					entry_n = upd_s1.now_ms;
				end
				default: begin
					to_fault = 1'b1;
					reason   = FR_BAD_STATE;
				end
			endcase

			// common fault entry; the event carries the count as it stands
			if (to_fault) begin
				res_n.queue_clear_request = 1'b1;
				res_n.fault_reason        = reason;
				res_n.event_code          = EVT_FAULT;
				res_n.event_value         = att_n;
				st_n    = ST_FAULT;
				entry_n = upd_s1.now_ms;
			end
		end

		res_n.machine_state = st_n;
		res_n.attempt_count = att_n;
		res_n.retry_count   = ret_n;
		res_n.busy_flag     = st_n inside {[ST_STARTING:ST_RETRY_DELAY]};
		res_n.faulted_flag  = (st_n == ST_FAULT);
	end

	// control and sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			state_q     <= ST_IDLE;
			attempts_q  <= '0;
			retries_q   <= '0;
			entry_q     <= '0;
		end else begin
			if (update.ready) valid_s1 <= update.valid;
			if (advance) begin
				res_valid_q <= 1'b1;
				state_q     <= st_n;
				attempts_q  <= att_n;
				retries_q   <= ret_n;
				entry_q     <= entry_n;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (update.ready && update.valid) begin
			upd_s1.estop_active   <= update.estop_active;
			upd_s1.busy_confirmed <= update.busy_confirmed;
			upd_s1.busy_raw       <= update.busy_raw;
			upd_s1.queue_empty    <= update.queue_empty;
			upd_s1.dequeue_ok     <= update.dequeue_ok;
			upd_s1.relay_start_ok <= update.relay_start_ok;
			upd_s1.relay_running  <= update.relay_running;
			upd_s1.clear_fault    <= update.clear_fault;
			upd_s1.now_ms         <= update.now_ms;
		end
		if (advance) res_q <= res_n;
	end

	// result beat
	assign result.valid               = res_valid_q;
	assign result.machine_state       = res_q.machine_state;
	assign result.attempt_count       = res_q.attempt_count;
	assign result.retry_count         = res_q.retry_count;
	assign result.dequeue_request     = res_q.dequeue_request;
	assign result.relay_start_request = res_q.relay_start_request;
	assign result.queue_clear_request = res_q.queue_clear_request;
	assign result.event_code          = res_q.event_code;
	assign result.retry_started       = res_q.retry_started;
	assign result.event_value         = res_q.event_value;
	assign result.fault_reason        = res_q.fault_reason;
	assign result.busy_flag           = res_q.busy_flag;
	assign result.faulted_flag        = res_q.faulted_flag;

	// a fault reason is reported only with the beat that enters fault
	a_reason_in_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.fault_reason != FR_NONE) |-> res_q.faulted_flag)
		else $error("fault reason reported outside fault state");

	// an active emergency stop always lands in the estop state
	a_estop_wins: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && upd_s1.estop_active) |=> (state_q == ST_ESTOP))
		else $error("estop did not override the sequencer");

	// retries stay below attempts
	a_retry_below_attempts: assert property (@(posedge clk) disable iff (!arst_n)
		(retries_q == '0) || (retries_q < attempts_q))
		else $error("retry count not below attempt count");

	// the input stage only moves on when its result can be stored
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready) |=> $stable(res_q))
		else $error("result overwritten while stalled");

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the wash start retry sequencer: directed sequences, then shaped random updates.
`timescale 1ns / 1ps
module tb_top;
	import wsrs_pkg::*;

	localparam int RUN_LIMIT   = 1_000_000;
	localparam int HOLD_CYCLES = 300;
	localparam int PRINT_CAP   = 40;

	// sequencer state codes
	typedef enum logic [STATE_W-1:0] {
		ST_IDLE        = 4'd0,
		ST_STARTING    = 4'd1,
		ST_WAIT_BUSY   = 4'd2,
		ST_RUNNING     = 4'd3,
		ST_RELEASE     = 4'd4,
		ST_QUEUE_DELAY = 4'd5,
		ST_RETRY_DELAY = 4'd6,
		ST_FAULT       = 4'd7,
		ST_ESTOP       = 4'd8
	} wash_state_t;

	typedef struct packed {
		logic              estop;
		logic              busy_c;
		logic              busy_r;
		logic              q_empty;
		logic              deq_ok;
		logic              relay_ok;
		logic              relay_run;
		logic              clr;
		logic [TIME_W-1:0] now;
	} wash_update_t;

	typedef struct packed {
		logic [STATE_W-1:0]  state;
		logic [COUNT_W-1:0]  attempts;
		logic [COUNT_W-1:0]  retries;
		logic                deq;
		logic                relay;
		logic                qclr;
		logic [EVENT_W-1:0]  evt;
		logic                retry;
		logic [COUNT_W-1:0]  val;
		logic [REASON_W-1:0] reason;
		logic                busy;
		logic                faulted;
	} wash_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	wsrs_upd_if upd_bus ();
	wsrs_res_if res_bus ();

	wash_start_retry_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.update    (upd_bus),
		.result    (res_bus)
	);

	// predicted sequencer state and settings
	wash_state_t        cur_state;
	logic [COUNT_W-1:0] attempts;
	logic [COUNT_W-1:0] retries;
	logic [TIME_W-1:0]  entered_ms;
	logic [COUNT_W-1:0] set_max_attempts;
	logic [SEC_W-1:0]   set_retry_s;
	logic [SEC_W-1:0]   set_inter_s;

	wash_result_t predicted_results[$];
	wash_result_t head_result;

	logic [TIME_W-1:0] clock_ms;
	bit                gaps_on;
	bit                hold_request;
	int                cycle_count;
	int                mismatches;
	int                updates_sent;
	int                results_checked;
	int                faults_seen;
	int                estops_seen;
	int                peak_attempts;

	function automatic bit roll(input int pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	function automatic int gap_len();
		return roll(90) ? $urandom_range(3, 1) : $urandom_range(40, 10);
	endfunction

	function automatic logic [TIME_W-1:0] to_ms(input logic [SEC_W-1:0] sec);
		return {16'd0, sec} * 32'd1000;
	endfunction

	function automatic void enter_state(input wash_state_t s, input logic [TIME_W-1:0] now);
		cur_state  = s;
		entered_ms = now;
	endfunction

	// elapsed time since state entry, modulo 2^32
	function automatic bit delay_elapsed(input logic [SEC_W-1:0] sec,
			input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] el;
		el = now - entered_ms;
		return el >= to_ms(sec);
	endfunction

	// one update of the sequencer; returns the result beat it causes
	function automatic wash_result_t advance_sequencer(input wash_update_t u);
		wash_result_t        r;
		bit                  fault_now;
		logic [REASON_W-1:0] why;
		r         = '0;
		fault_now = 1'b0;
		why       = FR_NONE;
		if (u.estop) begin
			if (cur_state != ST_ESTOP) begin
				r.qclr   = 1'b1;
				r.evt    = EVT_ESTOP_ACTIVE;
				attempts = '0;
				retries  = '0;
				enter_state(ST_ESTOP, u.now);
			end else if (!u.q_empty) begin
				r.qclr = 1'b1;
			end
		end else begin
			// leaving estop lands in idle, then idle is handled in the same update
			if (cur_state == ST_ESTOP) begin
				r.evt    = EVT_ESTOP_CLEARED;
				attempts = '0;
				retries  = '0;
				enter_state(ST_IDLE, u.now);
			end
			case (cur_state)
				ST_IDLE: begin
					attempts = '0;
					retries  = '0;
					if (!u.q_empty) begin
						r.deq = 1'b1;
						if (u.deq_ok) begin
							enter_state(ST_STARTING, u.now);
						end else begin
							fault_now = 1'b1;
							why       = FR_IDLE_DEQUEUE;
						end
					end
				end
				ST_STARTING: begin
					r.relay = 1'b1;
					if (u.relay_ok) begin
						if (attempts < 8'd255) attempts = attempts + 8'd1;
						if (attempts > 8'd1) retries = attempts - 8'd1;
						r.retry = (retries != 0);
						r.evt   = EVT_START_ATTEMPT;
						r.val   = attempts;
						enter_state(ST_WAIT_BUSY, u.now);
					end else begin
						fault_now = 1'b1;
						why       = FR_RELAY_FAILURE;
					end
				end
				ST_WAIT_BUSY: begin
					if (u.busy_c) begin
						r.evt = EVT_STARTED;
						r.val = attempts;
						enter_state(ST_RUNNING, u.now);
					end else if (!u.relay_run) begin
						if (attempts >= set_max_attempts) begin
							fault_now = 1'b1;
							why       = FR_NO_BUSY;
						end else begin
							enter_state(ST_RETRY_DELAY, u.now);
						end
					end
				end
				ST_RETRY_DELAY: begin
					if (delay_elapsed(set_retry_s, u.now)) enter_state(ST_STARTING, u.now);
				end
				ST_RUNNING: begin
					if (!u.busy_r) enter_state(ST_RELEASE, u.now);
				end
				ST_RELEASE: begin
					if (u.busy_r) begin
						enter_state(ST_RUNNING, u.now);
					end else if (!u.busy_c) begin
						r.evt    = EVT_COMPLETED;
						r.val    = attempts;
						attempts = '0;
						retries  = '0;
						enter_state(u.q_empty ? ST_IDLE : ST_QUEUE_DELAY, u.now);
					end
				end
				ST_QUEUE_DELAY: begin
					if (u.q_empty) begin
						enter_state(ST_IDLE, u.now);
					end else if (delay_elapsed(set_inter_s, u.now)) begin
						r.deq = 1'b1;
						if (!u.deq_ok) begin
							fault_now = 1'b1;
							why       = FR_QUEUED_LAUNCH;
						end else begin
							attempts = '0;
							retries  = '0;
							enter_state(ST_STARTING, u.now);
						end
					end
				end
				ST_FAULT: begin
					if (u.clr) r.qclr = 1'b1;
					attempts = '0;
					retries  = '0;
					enter_state(ST_IDLE, u.now);
				end
				default: begin
					fault_now = 1'b1;
					why       = FR_BAD_STATE;
				end
			endcase
		end
		// a fault replaces any event raised earlier in the update
		if (fault_now) begin
			r.qclr   = 1'b1;
			r.reason = why;
			r.evt    = EVT_FAULT;
			r.val    = attempts;
			enter_state(ST_FAULT, u.now);
		end
		r.state    = cur_state;
		r.attempts = attempts;
		r.retries  = retries;
		r.busy     = cur_state inside {[ST_STARTING:ST_RETRY_DELAY]};
		r.faulted  = (cur_state == ST_FAULT);
		return r;
	endfunction

	// directed update: estop, busy_c, busy_r, q_empty, deq_ok, relay_ok, relay_run, clr, now
	function automatic wash_update_t upd(input bit e, input bit bc, input bit br, input bit qe,
			input bit dok, input bit rok, input bit rrun, input bit clr,
			input logic [TIME_W-1:0] now);
		wash_update_t u;
		u = {e, bc, br, qe, dok, rok, rrun, clr, now};
		return u;
	endfunction

	// random update shaped by the predicted state so that washes run to completion
	function automatic wash_update_t random_update();
		wash_update_t      u;
		logic [31:0]       flags;
		logic [TIME_W-1:0] wait_ms;
		flags = $urandom;
		u     = '0;
		{u.estop, u.busy_c, u.busy_r, u.q_empty, u.deq_ok, u.relay_ok, u.relay_run, u.clr} =
			flags[7:0];
		if (!roll(8)) begin
			u.estop = (cur_state == ST_ESTOP) ? roll(60) : roll(3);
			case (cur_state)
				ST_IDLE: begin
					u.q_empty = roll(25);
					u.deq_ok  = roll(90);
				end
				ST_STARTING:    u.relay_ok = roll(90);
				ST_WAIT_BUSY:   u.busy_c   = roll(40);
				ST_RUNNING:     u.busy_r   = roll(75);
				ST_RELEASE:     u.busy_r   = roll(30);
				ST_QUEUE_DELAY: begin
					u.q_empty = roll(20);
					u.deq_ok  = roll(90);
				end
				default: ;
			endcase
		end
		// time mostly creeps forward; delays are often hit right at their edge
		wait_ms = to_ms(cur_state == ST_RETRY_DELAY ? set_retry_s : set_inter_s);
		if (roll(3)) begin
			clock_ms = $urandom;
		end else if (roll(2)) begin
			clock_ms = 32'hFFFF_FFFF - $urandom_range(3000, 0);
		end else if ((cur_state inside {ST_RETRY_DELAY, ST_QUEUE_DELAY}) && roll(40)) begin
			clock_ms = entered_ms + wait_ms + $urandom_range(2, 0) - 1;
		end else begin
			clock_ms = clock_ms + $urandom_range(200, 0);
		end
		u.now = clock_ms;
		return u;
	endfunction

	// offer one beat, predict it once accepted, then maybe idle
	task automatic send_update(input wash_update_t u);
		upd_bus.valid          <= 1'b1;
		upd_bus.estop_active   <= u.estop;
		upd_bus.busy_confirmed <= u.busy_c;
		upd_bus.busy_raw       <= u.busy_r;
		upd_bus.queue_empty    <= u.q_empty;
		upd_bus.dequeue_ok     <= u.deq_ok;
		upd_bus.relay_start_ok <= u.relay_ok;
		upd_bus.relay_running  <= u.relay_run;
		upd_bus.clear_fault    <= u.clr;
		upd_bus.now_ms         <= u.now;
		@(posedge clk);
		while (!upd_bus.ready) @(posedge clk);
		predicted_results.push_back(advance_sequencer(u));
		updates_sent++;
		if (gaps_on && roll(20)) begin
			upd_bus.valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	task automatic run_random(input int n);
		repeat (n) send_update(random_update());
	endtask

	// stop offering, wait for every result, then let the pipeline empty
	task automatic settle();
		upd_bus.valid <= 1'b0;
		while (predicted_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [COUNT_W-1:0] max_att, input logic [SEC_W-1:0] retry_s,
			input logic [SEC_W-1:0] inter_s);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MAX_ATTEMPTS;
		cfg_wdata <= {8'd0, max_att};
		@(posedge clk);
		cfg_index <= CFG_RETRY_DELAY;
		cfg_wdata <= retry_s;
		@(posedge clk);
		cfg_index <= CFG_INTER_WASH_DELAY;
		cfg_wdata <= inter_s;
		@(posedge clk);
		cfg_we <= 1'b0;
		set_max_attempts = max_att;
		set_retry_s      = retry_s;
		set_inter_s      = inter_s;
		@(posedge clk);
	endtask

	// full wash with a busy bounce, then a queued launch whose dequeue fails
	task automatic test_nominal_wash();
		send_update(upd(0, 0, 0, 1, 0, 0, 0, 0, 32'd1000));
		send_update(upd(0, 0, 0, 0, 1, 0, 0, 0, 32'd1010));
		send_update(upd(0, 0, 0, 0, 0, 1, 0, 0, 32'd1020));
		send_update(upd(0, 1, 1, 0, 0, 0, 1, 0, 32'd1030));
		send_update(upd(0, 1, 0, 0, 0, 0, 0, 0, 32'd1040));
		send_update(upd(0, 1, 1, 0, 0, 0, 0, 0, 32'd1050));
		send_update(upd(0, 1, 0, 0, 0, 0, 0, 0, 32'd1060));
		send_update(upd(0, 0, 0, 0, 0, 0, 0, 0, 32'd1070));
		send_update(upd(0, 0, 0, 0, 1, 0, 0, 0, 32'd11069));
		send_update(upd(0, 0, 0, 0, 0, 0, 0, 0, 32'd11070));
		send_update(upd(0, 0, 0, 0, 0, 0, 0, 1, 32'd11100));
		settle();
	endtask

	// busy never follows the relay: retries until the attempt limit faults
	task automatic test_retry_to_fault();
		send_update(upd(0, 0, 0, 0, 1, 0, 0, 0, 32'd20000));
		send_update(upd(0, 0, 0, 1, 0, 1, 0, 0, 32'd20010));
		send_update(upd(0, 0, 0, 1, 0, 0, 0, 0, 32'd20020));
		send_update(upd(0, 0, 0, 1, 0, 0, 0, 0, 32'd25019));
		send_update(upd(0, 0, 0, 1, 0, 0, 0, 0, 32'd25020));
		send_update(upd(0, 0, 0, 1, 0, 1, 0, 0, 32'd25030));
		send_update(upd(0, 0, 0, 1, 0, 0, 0, 0, 32'd25040));
		send_update(upd(0, 0, 0, 1, 0, 0, 0, 0, 32'd30040));
		send_update(upd(0, 0, 0, 1, 0, 1, 0, 0, 32'd30050));
		send_update(upd(0, 0, 0, 1, 0, 0, 0, 0, 32'd30060));
		settle();
	endtask

	// estop from fault, held with and without pending washes, then a failed dequeue
	// on release so the fault event replaces the estop-cleared event
	task automatic test_estop_override();
		send_update(upd(1, 0, 0, 0, 0, 0, 0, 0, 32'd40000));
		send_update(upd(1, 0, 0, 0, 0, 0, 0, 0, 32'd40010));
		send_update(upd(1, 0, 0, 1, 0, 0, 0, 0, 32'd40020));
		send_update(upd(0, 0, 0, 0, 0, 0, 0, 0, 32'd40030));
		send_update(upd(0, 0, 0, 1, 0, 0, 0, 0, 32'd40040));
		settle();
	endtask

	task automatic test_reset_settings_random();
		run_random(200);
		settle();
	endtask

	task automatic test_zero_settings();
		configure(8'd0, 16'd0, 16'd0);
		run_random(200);
		settle();
	endtask

	// drive the attempt counter all the way to 255 before the no-busy fault
	task automatic test_attempt_ceiling();
		wash_update_t u;
		configure(8'd255, 16'd0, 16'hFFFF);
		u       = random_update();
		u.estop = 1'b1;
		send_update(u);
		u         = random_update();
		u.estop   = 1'b0;
		u.q_empty = 1'b0;
		u.deq_ok  = 1'b1;
		send_update(u);
		while (cur_state != ST_FAULT && cur_state != ST_ESTOP) begin
			u       = random_update();
			u.estop = 1'b0;
			if (cur_state == ST_STARTING) u.relay_ok = 1'b1;
			if (cur_state == ST_WAIT_BUSY) begin
				u.busy_c    = 1'b0;
				u.relay_run = 1'b0;
			end
			send_update(u);
		end
		settle();
	endtask

	// longest delays, back to back with no idling on either side
	task automatic test_long_delays();
		configure(8'd1, 16'hFFFF, 16'hFFFF);
		gaps_on = 1'b0;
		run_random(200);
		settle();
		gaps_on = 1'b1;
	endtask

	// result side holds off while beats keep coming, so the block stalls its input
	task automatic test_backpressure();
		configure(8'($urandom_range(6, 2)), 16'($urandom_range(20, 1)),
			16'($urandom_range(20, 1)));
		hold_request = 1'b1;
		run_random(200);
		settle();
	endtask

	task automatic test_mixed_settings();
		repeat (3) begin
			configure(8'($urandom_range(255, 0)), 16'($urandom_range(65535, 0)),
				16'($urandom_range(65535, 0)));
			run_random(50);
			settle();
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= RUN_LIMIT);
		$display("tb: failure");
		$finish;
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		res_bus.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				res_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (gaps_on && roll(20)) begin
				res_bus.ready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
			end else begin
				res_bus.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (predicted_results.size() == 0) begin
				mismatches++;
				if (mismatches <= PRINT_CAP)
					$display("%0t: result beat with no prediction, expected none, got state %0d",
						$time, res_bus.machine_state);
			end else begin
				head_result = predicted_results.pop_front();
				results_checked++;
				compare_field("machine_state", head_result.state, res_bus.machine_state);
				compare_field("attempt_count", head_result.attempts, res_bus.attempt_count);
				compare_field("retry_count", head_result.retries, res_bus.retry_count);
				compare_field("dequeue_request", head_result.deq, res_bus.dequeue_request);
				compare_field("relay_start_request", head_result.relay,
					res_bus.relay_start_request);
				compare_field("queue_clear_request", head_result.qclr,
					res_bus.queue_clear_request);
				compare_field("event_code", head_result.evt, res_bus.event_code);
				compare_field("retry_started", head_result.retry, res_bus.retry_started);
				compare_field("event_value", head_result.val, res_bus.event_value);
				compare_field("fault_reason", head_result.reason, res_bus.fault_reason);
				compare_field("busy_flag", head_result.busy, res_bus.busy_flag);
				compare_field("faulted_flag", head_result.faulted, res_bus.faulted_flag);
				if (head_result.reason != FR_NONE) faults_seen++;
				if (head_result.evt == EVT_ESTOP_ACTIVE) estops_seen++;
				if (head_result.attempts > peak_attempts) peak_attempts = head_result.attempts;
			end
		end
	end

	// test sequence
	initial begin
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = CFG_MAX_ATTEMPTS;
		cfg_wdata              = '0;
		upd_bus.valid          = 1'b0;
		upd_bus.estop_active   = 1'b0;
		upd_bus.busy_confirmed = 1'b0;
		upd_bus.busy_raw       = 1'b0;
		upd_bus.queue_empty    = 1'b1;
		upd_bus.dequeue_ok     = 1'b0;
		upd_bus.relay_start_ok = 1'b0;
		upd_bus.relay_running  = 1'b0;
		upd_bus.clear_fault    = 1'b0;
		upd_bus.now_ms         = '0;
		cycle_count            = 0;
		mismatches             = 0;
		updates_sent           = 0;
		results_checked        = 0;
		faults_seen            = 0;
		estops_seen            = 0;
		peak_attempts          = 0;
		hold_request           = 1'b0;
		gaps_on                = 1'b1;
		clock_ms               = 32'd50000;
		cur_state              = ST_IDLE;
		attempts               = '0;
		retries                = '0;
		entered_ms             = '0;
		set_max_attempts       = MAX_ATTEMPTS_RST;
		set_retry_s            = 16'd5;
		set_inter_s            = 16'd10;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_nominal_wash();
		test_retry_to_fault();
		test_estop_override();
		test_reset_settings_random();
		test_zero_settings();
		test_attempt_ceiling();
		test_long_delays();
		test_backpressure();
		test_mixed_settings();

		$display("run covered %0d updates and %0d checked results, %0d mismatches",
			updates_sent, results_checked, mismatches);
		$display("faults entered %0d, estop entries %0d, highest attempt count %0d",
			faults_seen, estops_seen, peak_attempts);
		if (mismatches == 0 && predicted_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
